// ===== src/frame_interval_moving_average_unit_defines.svh =====
// Assertion macros shared by the frame interval averaging checker.
`ifndef FRAME_INTERVAL_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define FRAME_INTERVAL_MOVING_AVERAGE_UNIT_DEFINES_SVH

// Check a property while the block is out of reset.
`define FIMA_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define FIMA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/fima_pkg.sv =====
// Shared types and codes for the frame interval moving average unit.
`timescale 1ns / 1ps

package fima_pkg;

    localparam int unsigned OUT_WIDTH   = 32;
    localparam int unsigned WIN_WIDTH   = 7;
    localparam int unsigned CFG_IDX_W   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECENT_WINDOW    = 2'd1;

    // Division slots, run in this order.
    localparam logic [1:0] DIV_MEAN_ALL = 2'd0;
    localparam logic [1:0] DIV_MEAN_REC = 2'd1;
    localparam logic [1:0] DIV_RATE_ALL = 2'd2;
    localparam logic [1:0] DIV_RATE_REC = 2'd3;

    typedef struct packed {
        logic       capture;
        logic       update;
        logic       walk;
        logic       div_start;
        logic       div_store;
        logic [1:0] div_sel;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
        logic div_done;
    } sts_t;

endpackage

// ===== src/fima_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fima_div #(
    parameter int unsigned W = 40
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(W + 1);

    logic [W:0]       rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             active_reg;
    logic             done_reg;

    logic [W:0] trial;
    logic       ge;

    assign trial = {rem_reg[W-1:0], quo_reg[W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                active_reg <= 1'b1;
            end else if (active_reg && cnt_reg == CNT_W'(1)) begin
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
            cnt_reg <= CNT_W'(W);
        end else if (active_reg) begin
            rem_reg <= ge ? (trial - {1'b0, dvs_reg}) : trial;
            quo_reg <= {quo_reg[W-2:0], ge};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/fima_dp.sv =====
// Datapath: history ring, running total, window walk, products and divider.
`timescale 1ns / 1ps

module fima_dp #(
    parameter int unsigned HISTORY_DEPTH = 64,
    parameter int unsigned TIME_WIDTH    = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  fima_pkg::cmd_t                         cmd,
    output fima_pkg::sts_t                         sts,
    input  logic                                   cfg_wr_en,
    input  logic [fima_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fima_pkg::OUT_WIDTH-1:0]         cfg_wdata,
    input  logic [TIME_WIDTH-1:0]                  s_frame_timestamp,
    output logic [fima_pkg::OUT_WIDTH-1:0]         m_mean_interval_all,
    output logic [fima_pkg::OUT_WIDTH-1:0]         m_mean_interval_recent,
    output logic [fima_pkg::OUT_WIDTH-1:0]         m_rate_all,
    output logic [fima_pkg::OUT_WIDTH-1:0]         m_rate_recent,
    output logic [fima_pkg::WIN_WIDTH-1:0]         m_history_count
);

    localparam int unsigned OW   = fima_pkg::OUT_WIDTH;
    localparam int unsigned WINW = fima_pkg::WIN_WIDTH;
    localparam int unsigned CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned AW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned TOTW = TIME_WIDTH + CW;
    localparam int unsigned PW   = CW + OW;
    localparam int unsigned DW   = (TOTW > PW) ? TOTW : PW;
    localparam int unsigned MW   = (CW > WINW) ? CW : WINW;
    localparam logic [MW-1:0] CNT_SAT = MW'((1 << WINW) - 1);

    logic [TIME_WIDTH-1:0] ring_mem [HISTORY_DEPTH];

    logic [OW-1:0]         tps_reg;
    logic [WINW-1:0]       win_reg;
    logic [TIME_WIDTH-1:0] prev_ts_reg;
    logic [TIME_WIDTH-1:0] interval_reg;
    logic [TIME_WIDTH-1:0] rdata_reg;
    logic [AW-1:0]         wp_reg;
    logic [CW-1:0]         count_reg;
    logic [TOTW-1:0]       total_reg;
    logic [CW-1:0]         w_reg;
    logic [AW-1:0]         walk_pos_reg;
    logic [CW-1:0]         walk_left_reg;
    logic                  pend_reg;
    logic [TOTW-1:0]       sum_reg;
    logic [PW-1:0]         prod_all_reg;
    logic [PW-1:0]         prod_rec_reg;
    logic [OW-1:0]         res_mean_all_reg;
    logic [OW-1:0]         res_mean_rec_reg;
    logic [OW-1:0]         res_rate_all_reg;
    logic [OW-1:0]         res_rate_rec_reg;
    logic [OW-1:0]         out_mean_all_reg;
    logic [OW-1:0]         out_mean_rec_reg;
    logic [OW-1:0]         out_rate_all_reg;
    logic [OW-1:0]         out_rate_rec_reg;
    logic [WINW-1:0]       out_count_reg;

    logic          full;
    logic [AW-1:0] wp_next;
    logic [CW-1:0] count_next;
    logic [MW-1:0] win_ext;
    logic [MW-1:0] cnt_ext;
    logic [CW-1:0] w_next;
    logic [AW-1:0] pos_dec;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] div_dividend;
    logic [DW-1:0] div_divisor;
    logic [DW-1:0] div_quotient;
    logic [OW-1:0] q_sat;
    logic          div_done;

    assign full       = count_reg == CW'(HISTORY_DEPTH);
    assign wp_next    = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
    assign count_next = full ? count_reg : count_reg + CW'(1);
    assign win_ext    = MW'(win_reg);
    assign cnt_ext    = MW'(count_next);
    assign w_next     = (win_ext < cnt_ext) ? CW'(win_ext) : count_next;
    assign pos_dec    = (walk_pos_reg == '0) ? AW'(HISTORY_DEPTH - 1)
                                             : walk_pos_reg - AW'(1);
    assign rd_addr    = cmd.capture ? wp_reg : pos_dec;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg <= OW'(1000000);
            win_reg <= WINW'(16);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fima_pkg::CFG_TICKS_PER_SECOND: tps_reg <= cfg_wdata;
                fima_pkg::CFG_RECENT_WINDOW:    win_reg <= cfg_wdata[WINW-1:0];
                default: ;
            endcase
        end
    end

    // History memory: one write, one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            ring_mem[wp_reg] <= interval_reg;
        end
        rdata_reg <= ring_mem[rd_addr];
    end

    // History state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_ts_reg   <= '0;
            wp_reg        <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            walk_left_reg <= '0;
            pend_reg      <= 1'b0;
        end else begin
            if (cmd.capture) begin
                prev_ts_reg <= s_frame_timestamp;
            end
            if (cmd.update) begin
                total_reg     <= total_reg + TOTW'(interval_reg)
                                 - (full ? TOTW'(rdata_reg) : '0);
                wp_reg        <= wp_next;
                count_reg     <= count_next;
                walk_left_reg <= w_next;
                pend_reg      <= 1'b0;
            end else if (cmd.walk) begin
                pend_reg <= walk_left_reg != '0;
                if (walk_left_reg != '0) begin
                    walk_left_reg <= walk_left_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            interval_reg <= s_frame_timestamp - prev_ts_reg;
        end
        if (cmd.update) begin
            w_reg        <= w_next;
            walk_pos_reg <= wp_next;
            sum_reg      <= '0;
        end else if (cmd.walk) begin
            if (walk_left_reg != '0) begin
                walk_pos_reg <= pos_dec;
            end
            if (pend_reg) begin
                sum_reg <= sum_reg + TOTW'(rdata_reg);
            end
            prod_all_reg <= PW'(count_reg) * PW'(tps_reg);
            prod_rec_reg <= PW'(w_reg) * PW'(tps_reg);
        end
    end

    always_comb begin
        unique case (cmd.div_sel)
            fima_pkg::DIV_MEAN_ALL: begin
                div_dividend = DW'(total_reg);
                div_divisor  = DW'(count_reg);
            end
            fima_pkg::DIV_MEAN_REC: begin
                div_dividend = DW'(sum_reg);
                div_divisor  = DW'(w_reg);
            end
            fima_pkg::DIV_RATE_ALL: begin
                div_dividend = DW'(prod_all_reg);
                div_divisor  = DW'(total_reg);
            end
            default: begin
                div_dividend = DW'(prod_rec_reg);
                div_divisor  = DW'(sum_reg);
            end
        endcase
    end

    // Zero divisor yields all ones, which saturates as a rate must.
    fima_div #(
        .W (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign q_sat = (|div_quotient[DW-1:OW]) ? '1 : div_quotient[OW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.div_store) begin
            unique case (cmd.div_sel)
                fima_pkg::DIV_MEAN_ALL: res_mean_all_reg <= q_sat;
                fima_pkg::DIV_MEAN_REC: res_mean_rec_reg <= (w_reg == '0) ? '0 : q_sat;
                fima_pkg::DIV_RATE_ALL: res_rate_all_reg <= q_sat;
                default:                res_rate_rec_reg <= (w_reg == '0) ? '0 : q_sat;
            endcase
        end
        if (cmd.out_load) begin
            out_mean_all_reg <= res_mean_all_reg;
            out_mean_rec_reg <= res_mean_rec_reg;
            out_rate_all_reg <= res_rate_all_reg;
            out_rate_rec_reg <= res_rate_rec_reg;
            out_count_reg    <= (MW'(count_reg) > CNT_SAT) ? CNT_SAT[WINW-1:0]
                                                           : WINW'(count_reg);
        end
    end

    // Only looked at by the controller while it walks.
    assign sts.walk_done = (walk_left_reg == '0) && !pend_reg;
    assign sts.div_done  = div_done;

    assign m_mean_interval_all    = out_mean_all_reg;
    assign m_mean_interval_recent = out_mean_rec_reg;
    assign m_rate_all             = out_rate_all_reg;
    assign m_rate_recent          = out_rate_rec_reg;
    assign m_history_count        = out_count_reg;

endmodule

// ===== src/fima_ctrl.sv =====
// Controller state machine: sequences push, walk, divisions and output.
`timescale 1ns / 1ps

module fima_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output fima_pkg::cmd_t cmd,
    input  fima_pkg::sts_t sts
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_UPDATE   = 3'd1;
    localparam logic [2:0] ST_WALK     = 3'd2;
    localparam logic [2:0] ST_DIV_GO   = 3'd3;
    localparam logic [2:0] ST_DIV_WAIT = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sel_reg     <= fima_pkg::DIV_MEAN_ALL;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.div_sel  = sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (sts.walk_done) begin
                    sel_next   = fima_pkg::DIV_MEAN_ALL;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    cmd.div_store = 1'b1;
                    if (sel_reg == fima_pkg::DIV_RATE_REC) begin
                        state_next = ST_DONE;
                    end else begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

endmodule

// ===== src/frame_interval_moving_average_unit.sv =====
// Top level of the frame interval moving average unit.
`timescale 1ns / 1ps
// Usage:
//   Input channel s_*: one request per frame boundary carrying the free-running
//   timestamp. The wrapped difference from the previous mark is the interval.
//   Output channel m_*: one result request per input: mean interval over the
//   whole history and over the last recent_window frames, the two frame rates
//   and the entry count.
//   Config port cfg_*: write ticks_per_second (index 0) or recent_window
//   (index 1) while idle; other indexes are dropped.
// Sequencing:
//   The window walk reads w = min(window, count) history entries, one per cycle,
//   from the ring RAM; the shared one-bit-per-cycle divider then runs four
//   divisions. DW, the divider width, is max(TIME_WIDTH, 32) +
//   clog2(HISTORY_DEPTH+1). One frame is worked at a time.
// Reset: clears the history, the previous timestamp (first interval counts
//   from 0) and loads ticks_per_second = 1000000, recent_window = 16.
// Stall: a result waits in the output register; the next frame is still
//   accepted and computed, and is held until the waiting result is taken.

module frame_interval_moving_average_unit #(
    parameter int unsigned HISTORY_DEPTH = 64,
    parameter int unsigned TIME_WIDTH    = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [fima_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fima_pkg::OUT_WIDTH-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [TIME_WIDTH-1:0]               s_frame_timestamp,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fima_pkg::OUT_WIDTH-1:0]      m_mean_interval_all,
    output logic [fima_pkg::OUT_WIDTH-1:0]      m_mean_interval_recent,
    output logic [fima_pkg::OUT_WIDTH-1:0]      m_rate_all,
    output logic [fima_pkg::OUT_WIDTH-1:0]      m_rate_recent,
    output logic [fima_pkg::WIN_WIDTH-1:0]      m_history_count
);

    fima_pkg::cmd_t cmd;
    fima_pkg::sts_t sts;

    // Sequencer: idle -> push -> walk -> four divisions -> output load.
    fima_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Ring, totals, products, divider and the output register.
    fima_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_dp (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cmd                    (cmd),
        .sts                    (sts),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_index              (cfg_index),
        .cfg_wdata              (cfg_wdata),
        .s_frame_timestamp      (s_frame_timestamp),
        .m_mean_interval_all    (m_mean_interval_all),
        .m_mean_interval_recent (m_mean_interval_recent),
        .m_rate_all             (m_rate_all),
        .m_rate_recent          (m_rate_recent),
        .m_history_count        (m_history_count)
    );

endmodule

// ===== src/fima_checker.sv =====
// Port-level checker for the frame interval moving average unit, with bind.
`timescale 1ns / 1ps
`include "frame_interval_moving_average_unit_defines.svh"

module fima_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [fima_pkg::WIN_WIDTH-1:0] m_history_count
);

    // A pending result request holds until taken.
    `FIMA_ASSERT_RUN(a_m_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "m_valid dropped")

    // Every result follows at least one pushed interval.
    `FIMA_ASSERT_RUN(a_count_nonzero, aclk, aresetn, m_valid |-> m_history_count != '0, "zero count")

    // Reset leaves no result pending.
    `FIMA_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_valid, "m_valid after reset")

    // A result never shows the cycle right after an input is taken.
    `FIMA_ASSERT_RUN(a_no_instant, aclk, aresetn, s_valid && s_ready && !m_valid |=> !m_valid, "early result")

endmodule

bind frame_interval_moving_average_unit fima_checker u_fima_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_history_count (m_history_count)
);

// ===== sim/frame_interval_moving_average_checker.sv =====
// Result checker for the frame interval moving average unit.
`timescale 1ns / 1ps

module frame_interval_moving_average_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [fima_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fima_pkg::OUT_WIDTH-1:0]   cfg_wdata,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [31:0]                      s_frame_timestamp,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [31:0]                      m_mean_interval_all,
    input  logic [31:0]                      m_mean_interval_recent,
    input  logic [31:0]                      m_rate_all,
    input  logic [31:0]                      m_rate_recent,
    input  logic [6:0]                       m_history_count,
    output int                               error_count,
    output int                               pending_count
);

    localparam int DEPTH = 64;
    localparam logic [63:0] SAT = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] mean_all;
        logic [31:0] mean_recent;
        logic [31:0] rate_all;
        logic [31:0] rate_recent;
        logic [6:0]  count;
    } frame_stats_t;

    logic [31:0]  tick_rate;
    logic [6:0]   window_len;
    logic [31:0]  last_stamp;
    logic [31:0]  intervals [DEPTH];
    int           wr_pos;
    int           held;
    logic [63:0]  interval_sum;
    frame_stats_t stats_q[$];

    assign pending_count = stats_q.size();

    function automatic logic [31:0] clip32(logic [63:0] v);
        return (v > SAT) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [31:0] fps_of(logic [63:0] frames, logic [63:0] total);
        if (total == 0) return 32'hFFFF_FFFF;
        return clip32((frames * tick_rate) / total);
    endfunction

    task automatic push_frame(logic [31:0] stamp);
        logic [31:0]  gap;
        logic [63:0]  recent_sum;
        int           w;
        int           p;
        frame_stats_t r;
        gap = stamp - last_stamp;
        last_stamp = stamp;
        if (held >= DEPTH) begin
            interval_sum -= intervals[wr_pos];
            held = DEPTH;
        end else begin
            held++;
        end
        intervals[wr_pos] = gap;
        interval_sum += gap;
        wr_pos = (wr_pos + 1) % DEPTH;
        w = (window_len < held) ? window_len : held;
        recent_sum = 0;
        p = wr_pos;
        for (int k = 0; k < w; k++) begin
            p = (p == 0) ? DEPTH - 1 : p - 1;
            recent_sum += intervals[p];
        end
        r.mean_all = clip32(interval_sum / held);
        r.mean_recent = (w == 0) ? 32'd0 : clip32(recent_sum / w);
        r.rate_recent = (w == 0) ? 32'd0 : fps_of(w, recent_sum);
        r.rate_all = fps_of(held, interval_sum);
        r.count = held[6:0];
        stats_q.insert(stats_q.size(), r);
    endtask

    always @(posedge aclk) begin
        frame_stats_t e;
        frame_stats_t got;
        if (!aresetn) begin
            tick_rate <= 32'd1000000;
            window_len <= 7'd16;
            last_stamp = 0;
            wr_pos = 0;
            held = 0;
            interval_sum = 0;
            stats_q.delete();
            error_count <= 0;
        end else begin
            if (cfg_wr_en && cfg_index == fima_pkg::CFG_TICKS_PER_SECOND)
                tick_rate <= cfg_wdata;
            if (cfg_wr_en && cfg_index == fima_pkg::CFG_RECENT_WINDOW)
                window_len <= cfg_wdata[6:0];
            if (s_valid && s_ready) push_frame(s_frame_timestamp);
            if (m_valid && m_ready) begin
                got = '{m_mean_interval_all, m_mean_interval_recent, m_rate_all,
                        m_rate_recent, m_history_count};
                if (stats_q.size() == 0) begin
                    if (error_count < 10) $display("unexpected result %p", got);
                    error_count <= error_count + 1;
                end else begin
                    e = stats_q[0];
                    stats_q.delete(0);
                    if (e != got) begin
                        if (error_count < 10)
                            $display("mismatch exp %p got %p", e, got);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/frame_interval_moving_average_unit_tb.sv =====
// Testbench top: stimulus, configuration phases and verdict for the averaging unit.
`timescale 1ns / 1ps

module frame_interval_moving_average_unit_tb;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [fima_pkg::CFG_IDX_W-1:0] cfg_index = fima_pkg::CFG_TICKS_PER_SECOND;
    logic [31:0] cfg_wdata = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [31:0] s_frame_timestamp = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_mean_interval_all, m_mean_interval_recent, m_rate_all, m_rate_recent;
    logic [6:0]  m_history_count;
    int          error_count, pending_count;
    int          cycle_count = 0;
    bit          no_idle = 0;     // long stretch with idling off on both sides
    bit          hold_sink = 0;   // receiver hold-off for backpressure test
    logic [31:0] stamp = 0;       // running timestamp for well-formed frames

    always #6 aclk = ~aclk;

    frame_interval_moving_average_unit u_dut (.*);

    frame_interval_moving_average_checker u_check (.*);

    // Receiver: random stalls, or a full hold while hold_sink is set.
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else m_ready <= !hold_sink && (no_idle || $urandom_range(99) >= 38);
    end

    // Watchdog: covers ~1100 frames plus stalls; a longer run fails.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2_000_000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one timestamp request; wait for acceptance. Valid stays up after
    // acceptance so the next request can follow in the same step; drain drops it.
    task automatic send_frame(logic [31:0] ts);
        while (!no_idle && $urandom_range(99) < 38) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_frame_timestamp <= ts;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Step the running timestamp by a gap; mostly frame-like spacing.
    task automatic send_gap(logic [31:0] gap);
        stamp = stamp + gap;
        send_frame(stamp);
    endtask

    task automatic write_reg(logic [fima_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    // Stop offering, wait until every expected result has come back, then settle.
    task automatic drain;
        s_valid <= 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_gap;
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(3);
            default: return $urandom_range(40000, 5000);
        endcase
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) send_frame($urandom);  // jump, may wrap
            else send_gap(rand_gap());
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: first frame from 0, zero gap, wrap, extreme gaps.
        send_frame(32'd16667);
        stamp = 32'd16667;
        send_gap(0);
        send_gap(32'hFFFF_FFFF);
        send_gap(1);
        send_frame(32'hFFFF_FFF0);
        send_frame(32'h0000_0010);    // wraps
        stamp = 32'h10;
        for (int i = 0; i < 8; i++) send_gap(i[0] ? 32'hFFFF_FFFF : 32'd0);
        drain();

        // Window zero, undefined index, rate zero.
        write_reg(fima_pkg::CFG_RECENT_WINDOW, 0);
        write_reg(2'd2, 32'd5);
        write_reg(2'd3, 32'hFFFF_FFFF);
        write_reg(fima_pkg::CFG_TICKS_PER_SECOND, 0);
        send_gap(100);
        send_gap(0);
        drain();

        // Extremes: max rate, window above count / at depth, top window bits.
        write_reg(fima_pkg::CFG_TICKS_PER_SECOND, 32'hFFFF_FFFF);
        write_reg(fima_pkg::CFG_RECENT_WINDOW, 64);
        send_gap(1);
        send_gap(2);
        drain();
        write_reg(fima_pkg::CFG_RECENT_WINDOW, 32'hFFFF_FF7F);   // window 127
        send_gap(3);
        drain();

        // Random phases over several settings.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(fima_pkg::CFG_TICKS_PER_SECOND,
                      (ph == 0) ? 32'd1 : (ph == 1) ? 32'd1000000 : $urandom);
            write_reg(fima_pkg::CFG_RECENT_WINDOW, (ph == 2) ? 7'd1 : $urandom_range(64));
            if (ph == 3) no_idle = 1;
            if (ph == 5) fork
                begin
                    hold_sink = 1;
                    repeat (3000) @(posedge aclk);
                    hold_sink = 0;
                end
            join_none
            random_phase(135);
            no_idle = 0;
            drain();
        end

        drain();
        if (error_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
